### design/dsalc_pkg.sv
// ----------------------------------------------------------------------------
// dsalc_pkg
// Types, codes and a helper function shared by the drag-scroll converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dsalc_pkg;

    localparam int DPI_SLOTS = 8;
    localparam int DPI_LIMIT = (DPI_SLOTS < 8) ? DPI_SLOTS : 8;

    localparam int DELTA_W = 17;
    localparam int SUM_W   = 18;
    localparam int TOTAL_W = 24;
    localparam int FRAC_W  = 9;

    localparam logic [8:0]  GAIN_RESET     = 9'd32;
    localparam logic [14:0] LOCK_RESET     = 15'd3;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
    localparam logic [15:0] TAPPING_RESET  = 16'd200;
    localparam logic [3:0]  DPI_CNT_RESET  = 4'd3;

    typedef enum logic [2:0] {
        CFG_GAIN_H    = 3'd0,
        CFG_GAIN_V    = 3'd1,
        CFG_LOCK      = 3'd2,
        CFG_DEBOUNCE  = 3'd3,
        CFG_TAPPING   = 3'd4,
        CFG_INVERT    = 3'd5,
        CFG_DPI_COUNT = 3'd6
    } cfg_addr_e;

    typedef enum logic [2:0] {
        KEY_OTHER       = 3'd0,
        KEY_DPI         = 3'd1,
        KEY_DRAG_TOGGLE = 3'd2,
        KEY_VOLUME      = 3'd3,
        KEY_SLOW        = 3'd4,
        KEY_SCROLL      = 3'd5,
        KEY_DRAG_HOLD   = 3'd6
    } key_code_e;

    typedef enum logic [1:0] {
        VOL_NONE = 2'd0,
        VOL_UP   = 2'd1,
        VOL_DOWN = 2'd2
    } vol_tap_e;

    typedef enum logic [1:0] {
        CPI_NONE = 2'd0,
        CPI_SET  = 2'd1,
        CPI_SLOW = 2'd2,
        CPI_FAST = 2'd3
    } cpi_e;

    typedef enum logic [1:0] {
        LAYER_NONE  = 2'd0,
        LAYER_ENTER = 2'd1,
        LAYER_LEAVE = 2'd2
    } layer_e;

    typedef struct packed {
        logic [8:0]  gain_h;
        logic [8:0]  gain_v;
        logic [14:0] lock_threshold;
        logic [15:0] volume_debounce_ms;
        logic [15:0] tapping_term_ms;
        logic        invert_scroll;
        logic [3:0]  dpi_count;
    } cfg_t;

    typedef struct packed {
        logic                      cmd;
        logic signed [7:0]         move_x;
        logic signed [7:0]         move_y;
        logic signed [7:0]         wheel_h;
        logic signed [7:0]         wheel_v;
        logic [2:0]                key_code;
        logic                      key_pressed;
        logic [15:0]               now_ms;
        logic signed [DELTA_W-1:0] delta_h;
        logic signed [DELTA_W-1:0] delta_v;
    } item_t;

    typedef struct packed {
        logic signed [7:0] out_x;
        logic signed [7:0] out_y;
        logic signed [7:0] out_h;
        logic signed [7:0] out_v;
        logic [1:0]        volume_tap;
        logic              middle_click;
        logic [1:0]        cpi_change;
        logic [2:0]        dpi_index;
        logic [1:0]        layer_change;
        logic              pass_key;
    } result_t;

    typedef struct packed {
        logic signed [7:0]        whole;
        logic signed [FRAC_W-1:0] rem;
    } emit_t;

    // Splits an accumulator into its whole part toward zero, saturated and
    // optionally negated, and the fraction that stays behind.
    function automatic emit_t emit_whole(input logic signed [SUM_W-1:0] acc,
                                         input logic inv);
        logic                neg;
        logic [SUM_W-1:0]    mag;
        logic [SUM_W-9:0]    wm;
        logic [7:0]          rm;
        logic signed [7:0]   w;
        emit_t               r;
        neg = acc[SUM_W-1];
        mag = neg ? SUM_W'(-acc) : SUM_W'(acc);
        wm  = mag[SUM_W-1:8];
        rm  = mag[7:0];
        if (neg)
        begin
            w = (wm > (SUM_W-8)'(128)) ? -8'sd128 : -$signed(wm[7:0]);
        end
        else
        begin
            w = (wm > (SUM_W-8)'(127)) ? 8'sd127 : $signed(wm[7:0]);
        end
        if (inv)
        begin
            w = (w == -8'sd128) ? 8'sd127 : -w;
        end
        r.whole = w;
        r.rem   = neg ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
        return r;
    endfunction

endpackage

`default_nettype wire

### design/dsalc_in_stage.sv
// ----------------------------------------------------------------------------
// dsalc_in_stage
// Input register: unpacks a request and scales the motion by the gains.
// ----------------------------------------------------------------------------
`default_nettype none

module dsalc_in_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [55:0]      s_tdata,
    input  wire logic             s_tuser,
    input  wire dsalc_pkg::cfg_t  cfg,
    input  wire logic             take,
    output logic                  item_valid,
    output dsalc_pkg::item_t      item
);

    logic             valid_reg;
    logic             valid_next;
    dsalc_pkg::item_t item_reg;
    dsalc_pkg::item_t item_next;
    logic [8:0]       gain_h_eff;
    logic [8:0]       gain_v_eff;
    logic             accept;

    assign s_tready = !valid_reg || take;
    assign accept   = s_tvalid && s_tready;

    assign gain_h_eff = cfg.gain_h[8] ? 9'd256 : cfg.gain_h;
    assign gain_v_eff = cfg.gain_v[8] ? 9'd256 : cfg.gain_v;

    always_comb
    begin
        item_next.cmd         = s_tuser;
        item_next.move_x      = $signed(s_tdata[7:0]);
        item_next.move_y      = $signed(s_tdata[15:8]);
        item_next.wheel_h     = $signed(s_tdata[23:16]);
        item_next.wheel_v     = $signed(s_tdata[31:24]);
        item_next.key_code    = s_tdata[34:32];
        item_next.key_pressed = s_tdata[35];
        item_next.now_ms      = s_tdata[51:36];
        item_next.delta_h     = dsalc_pkg::DELTA_W'($signed(s_tdata[7:0]))
                                * $signed(dsalc_pkg::DELTA_W'({1'b0, gain_h_eff}));
        item_next.delta_v     = dsalc_pkg::DELTA_W'($signed(s_tdata[15:8]))
                                * $signed(dsalc_pkg::DELTA_W'({1'b0, gain_v_eff}));
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### design/dsalc_core.sv
// ----------------------------------------------------------------------------
// dsalc_core
// Mode and accumulator state, per-request decisions and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsalc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire dsalc_pkg::item_t  item,
    input  wire dsalc_pkg::cfg_t   cfg,
    input  wire logic              m_tready,
    output logic                   take,
    output logic                   out_valid,
    output dsalc_pkg::result_t     res
);

    localparam int TW = dsalc_pkg::TOTAL_W;
    localparam int SW = dsalc_pkg::SUM_W;
    localparam int FW = dsalc_pkg::FRAC_W;

    logic                 drag_mode_reg,   drag_mode_next;
    logic                 volume_mode_reg, volume_mode_next;
    logic                 lock_h_reg,      lock_h_next;
    logic                 lock_v_reg,      lock_v_next;
    logic                 moved_reg,       moved_next;
    logic signed [TW-1:0] total_h_reg,     total_h_next;
    logic signed [TW-1:0] total_v_reg,     total_v_next;
    logic signed [FW-1:0] frac_h_reg,      frac_h_next;
    logic signed [FW-1:0] frac_v_reg,      frac_v_next;
    logic [15:0]          volume_stamp_reg, volume_stamp_next;
    logic [15:0]          press_stamp_reg, press_stamp_next;
    logic [2:0]           dpi_sel_reg,     dpi_sel_next;
    logic                 out_valid_reg,   out_valid_next;
    dsalc_pkg::result_t   res_reg,         res_next;

    logic signed [TW:0]   sum_h, sum_v;
    logic signed [TW-1:0] sat_h, sat_v;
    logic [TW-1:0]        mag_h, mag_v;
    logic                 over_h, over_v;
    logic                 lk_h, lk_v;
    logic signed [SW-1:0] acc_h, acc_v;
    dsalc_pkg::emit_t     emit_h, emit_v;
    logic [3:0]           dpi_len;
    logic [3:0]           dpi_inc;
    logic [15:0]          vol_elapsed;
    logic [15:0]          press_elapsed;

    assign take = item_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        sum_h = (TW+1)'(total_h_reg) + (TW+1)'(item.delta_h);
        sum_v = (TW+1)'(total_v_reg) + (TW+1)'(item.delta_v);
        if (sum_h[TW] != sum_h[TW-1])
        begin
            sat_h = sum_h[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end
        else
        begin
            sat_h = sum_h[TW-1:0];
        end
        if (sum_v[TW] != sum_v[TW-1])
        begin
            sat_v = sum_v[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end
        else
        begin
            sat_v = sum_v[TW-1:0];
        end
        mag_h  = sat_h[TW-1] ? TW'(-sat_h) : TW'(sat_h);
        mag_v  = sat_v[TW-1] ? TW'(-sat_v) : TW'(sat_v);
        over_h = mag_h[TW-1:8] > (TW-8)'(cfg.lock_threshold);
        over_v = mag_v[TW-1:8] > (TW-8)'(cfg.lock_threshold);
        lk_h   = lock_h_reg;
        lk_v   = lock_v_reg;
        if (over_h)
        begin
            lk_v = 1'b1;
            lk_h = 1'b0;
        end
        if (over_v)
        begin
            lk_h = 1'b1;
            lk_v = 1'b0;
        end
        acc_h  = SW'(frac_h_reg) + (lk_h ? SW'(0) : SW'(item.delta_h));
        acc_v  = SW'(frac_v_reg) + (lk_v ? SW'(0) : SW'(item.delta_v));
        emit_h = dsalc_pkg::emit_whole(acc_h, cfg.invert_scroll);
        emit_v = dsalc_pkg::emit_whole(acc_v, cfg.invert_scroll);

        if (cfg.dpi_count > 4'(dsalc_pkg::DPI_LIMIT))
        begin
            dpi_len = 4'(dsalc_pkg::DPI_LIMIT);
        end
        else if (cfg.dpi_count == 4'd0)
        begin
            dpi_len = 4'd1;
        end
        else
        begin
            dpi_len = cfg.dpi_count;
        end
        dpi_inc       = {1'b0, dpi_sel_reg} + 4'd1;
        vol_elapsed   = item.now_ms - volume_stamp_reg;
        press_elapsed = item.now_ms - press_stamp_reg;
    end

    always_comb
    begin
        drag_mode_next    = drag_mode_reg;
        volume_mode_next  = volume_mode_reg;
        lock_h_next       = lock_h_reg;
        lock_v_next       = lock_v_reg;
        moved_next        = moved_reg;
        total_h_next      = total_h_reg;
        total_v_next      = total_v_reg;
        frac_h_next       = frac_h_reg;
        frac_v_next       = frac_v_reg;
        volume_stamp_next = volume_stamp_reg;
        press_stamp_next  = press_stamp_reg;
        dpi_sel_next      = dpi_sel_reg;
        res_next          = '0;
        out_valid_next    = take ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

        if (take)
        begin
            if (!item.cmd)
            begin
                moved_next     = (item.move_x != 8'sd0) || (item.move_y != 8'sd0);
                res_next.out_h = item.wheel_h;
                res_next.out_v = item.wheel_v;
                if (volume_mode_reg)
                begin
                    if (vol_elapsed > cfg.volume_debounce_ms)
                    begin
                        if (item.move_y < 8'sd0)
                        begin
                            res_next.volume_tap = dsalc_pkg::VOL_UP;
                        end
                        else if (item.move_y > 8'sd0)
                        begin
                            res_next.volume_tap = dsalc_pkg::VOL_DOWN;
                        end
                        volume_stamp_next = item.now_ms;
                    end
                end
                else if (drag_mode_reg)
                begin
                    total_h_next   = sat_h;
                    total_v_next   = sat_v;
                    lock_h_next    = lk_h;
                    lock_v_next    = lk_v;
                    frac_h_next    = emit_h.rem;
                    frac_v_next    = emit_v.rem;
                    res_next.out_h = emit_h.whole;
                    res_next.out_v = emit_v.whole;
                end
                else
                begin
                    res_next.out_x = item.move_x;
                    res_next.out_y = item.move_y;
                end
            end
            else
            begin
                volume_mode_next  = 1'b0;
                res_next.pass_key = 1'b1;
                case (dsalc_pkg::key_code_e'(item.key_code))
                    dsalc_pkg::KEY_DPI:
                    begin
                        if (item.key_pressed)
                        begin
                            dpi_sel_next = (dpi_inc >= dpi_len) ? 3'd0 : dpi_inc[2:0];
                            res_next.cpi_change = dsalc_pkg::CPI_SET;
                        end
                    end
                    dsalc_pkg::KEY_DRAG_TOGGLE:
                    begin
                        if (item.key_pressed)
                        begin
                            drag_mode_next = !drag_mode_reg;
                        end
                    end
                    dsalc_pkg::KEY_VOLUME:
                    begin
                        if (item.key_pressed)
                        begin
                            volume_mode_next  = 1'b1;
                            res_next.pass_key = 1'b0;
                        end
                    end
                    dsalc_pkg::KEY_SLOW:
                    begin
                        res_next.cpi_change = item.key_pressed ? dsalc_pkg::CPI_SLOW
                                                               : dsalc_pkg::CPI_FAST;
                    end
                    dsalc_pkg::KEY_SCROLL:
                    begin
                        drag_mode_next    = item.key_pressed;
                        res_next.pass_key = 1'b0;
                        if (item.key_pressed)
                        begin
                            res_next.layer_change = dsalc_pkg::LAYER_ENTER;
                            moved_next       = 1'b0;
                            frac_h_next      = '0;
                            frac_v_next      = '0;
                            total_h_next     = '0;
                            total_v_next     = '0;
                            lock_h_next      = 1'b0;
                            lock_v_next      = 1'b0;
                            press_stamp_next = item.now_ms;
                        end
                        else
                        begin
                            res_next.layer_change = dsalc_pkg::LAYER_LEAVE;
                            res_next.middle_click = !moved_reg
                                && (press_elapsed < cfg.tapping_term_ms);
                        end
                    end
                    dsalc_pkg::KEY_DRAG_HOLD:
                    begin
                        drag_mode_next = item.key_pressed;
                        total_h_next   = '0;
                        total_v_next   = '0;
                        lock_h_next    = 1'b0;
                        lock_v_next    = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        res_next.dpi_index = dpi_sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_mode_reg    <= 1'b0;
            volume_mode_reg  <= 1'b0;
            lock_h_reg       <= 1'b0;
            lock_v_reg       <= 1'b0;
            moved_reg        <= 1'b0;
            total_h_reg      <= '0;
            total_v_reg      <= '0;
            frac_h_reg       <= '0;
            frac_v_reg       <= '0;
            volume_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            dpi_sel_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            drag_mode_reg    <= drag_mode_next;
            volume_mode_reg  <= volume_mode_next;
            lock_h_reg       <= lock_h_next;
            lock_v_reg       <= lock_v_next;
            moved_reg        <= moved_next;
            total_h_reg      <= total_h_next;
            total_v_reg      <= total_v_next;
            frac_h_reg       <= frac_h_next;
            frac_v_reg       <= frac_v_next;
            volume_stamp_reg <= volume_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            dpi_sel_reg      <= dpi_sel_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### design/drag_scroll_axis_lock_converter_unit.sv
// ----------------------------------------------------------------------------
// drag_scroll_axis_lock_converter_unit
// Turns trackball reports and key events into pointer, scroll, volume and
// mode results, with drag scrolling and axis lock.
// ----------------------------------------------------------------------------
//   Channel  | Direction | Payload
//   s_*      | in        | tuser: cmd; tdata: move_x, move_y, wheel_h, wheel_v,
//            |           |   key_code, key_pressed, now_ms
//   m_*      | out       | tdata: out_x .. pass_key, one result per request
//   cfg_*    | in        | register writes, index 0..6
//
// A request is taken into the input register, where the motion is scaled,
// and its result is registered in the result register once that is free.
// One request is accepted every cycle while the result side keeps up.
// A stalled result holds; the input register still accepts one more request.
// Reset clears the modes, accumulators, stamps and DPI index at once.
// ----------------------------------------------------------------------------
`default_nettype none

module drag_scroll_axis_lock_converter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] move_x, [15:8] move_y, [23:16] wheel_h, [31:24] wheel_v,
    // [34:32] key_code, [35] key_pressed, [51:36] now_ms, [55:52] zero
    input  wire logic [55:0] s_tdata,
    // [0] cmd
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_x, [15:8] out_y, [23:16] out_h, [31:24] out_v,
    // [33:32] volume_tap, [34] middle_click, [36:35] cpi_change,
    // [39:37] dpi_index, [41:40] layer_change, [42] pass_key, [47:43] zero
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    dsalc_pkg::cfg_t    cfg_reg;
    dsalc_pkg::item_t   item;
    dsalc_pkg::result_t res;
    logic               item_valid;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_h             <= dsalc_pkg::GAIN_RESET;
            cfg_reg.gain_v             <= dsalc_pkg::GAIN_RESET;
            cfg_reg.lock_threshold     <= dsalc_pkg::LOCK_RESET;
            cfg_reg.volume_debounce_ms <= dsalc_pkg::DEBOUNCE_RESET;
            cfg_reg.tapping_term_ms    <= dsalc_pkg::TAPPING_RESET;
            cfg_reg.invert_scroll      <= 1'b0;
            cfg_reg.dpi_count          <= dsalc_pkg::DPI_CNT_RESET;
        end
        else if (cfg_we)
        begin
            case (dsalc_pkg::cfg_addr_e'(cfg_addr))
                dsalc_pkg::CFG_GAIN_H:    cfg_reg.gain_h             <= cfg_wdata[8:0];
                dsalc_pkg::CFG_GAIN_V:    cfg_reg.gain_v             <= cfg_wdata[8:0];
                dsalc_pkg::CFG_LOCK:      cfg_reg.lock_threshold     <= cfg_wdata[14:0];
                dsalc_pkg::CFG_DEBOUNCE:  cfg_reg.volume_debounce_ms <= cfg_wdata;
                dsalc_pkg::CFG_TAPPING:   cfg_reg.tapping_term_ms    <= cfg_wdata;
                dsalc_pkg::CFG_INVERT:    cfg_reg.invert_scroll      <= cfg_wdata[0];
                dsalc_pkg::CFG_DPI_COUNT: cfg_reg.dpi_count          <= cfg_wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    dsalc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dsalc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_reg),
        .m_tready   (m_tready),
        .take       (take),
        .out_valid  (m_tvalid),
        .res        (res)
    );

    assign m_tdata = {5'd0, res.pass_key, res.layer_change, res.dpi_index,
                      res.cpi_change, res.middle_click, res.volume_tap,
                      res.out_v, res.out_h, res.out_y, res.out_x};

endmodule

`default_nettype wire

### design/dsalc_checker.sv
// ----------------------------------------------------------------------------
// dsalc_checker
// Port-level checks on the result stream of the drag-scroll converter.
// ----------------------------------------------------------------------------
`default_nettype none

module dsalc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [55:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        cfg_we,
    input wire logic [2:0]  cfg_addr,
    input wire logic [15:0] cfg_wdata
);

    logic unused_ok;

    assign unused_ok = s_tvalid ^ s_tready ^ s_tuser ^ (^s_tdata) ^ cfg_we
                       ^ (^cfg_addr) ^ (^cfg_wdata);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_key_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[42] |-> m_tdata[33:0] == 34'd0)
        else $error("passed key result carries motion or scroll");

    a_tap_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[33:32] != 2'd0
        |-> m_tdata[36:34] == 3'd0 && m_tdata[42:40] == 3'd0)
        else $error("volume tap mixed with key outcome");

    a_codes_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:32] != 2'd3 && m_tdata[41:40] != 2'd3
                     && m_tdata[47:43] == 5'd0)
        else $error("undefined code or padding in result");

endmodule

bind drag_scroll_axis_lock_converter_unit dsalc_checker u_dsalc_checker (.*);

`default_nettype wire
